### rtl/core/iirtdf2_pkg.sv
// Shared types and constants for the transposed direct form II IIR filter.
package iirtdf2_pkg;

    localparam int ORDER_DEFAULT = 3;

    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 24;
    localparam int PROD_W     = SAMPLE_W + COEF_W;
    localparam int DLY_W      = 48;
    localparam int ACC_W      = DLY_W + 1;
    localparam int UPD_W      = DLY_W + 2;
    localparam int ROUND_SH   = 20;
    localparam int NUM_REGS   = 7;
    localparam int COEF_IDX_W = 3;
    localparam int TAP_W      = 2;

    localparam logic [COEF_IDX_W-1:0] REG_B0     = 3'd0;
    localparam logic [COEF_IDX_W-1:0] REG_A_BASE = 3'd3;

    localparam logic signed [COEF_W-1:0] COEF_B0_RESET = 24'sd1048576;

    typedef struct packed {
        logic                  load_x;
        logic                  mul_en;
        logic                  mul_y;
        logic [COEF_IDX_W-1:0] coef_idx;
        logic                  y_en;
        logic                  acc_en;
        logic                  upd_en;
        logic [TAP_W-1:0]      tap;
        logic                  out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_status;

endpackage

### rtl/core/iir_filter_transposed_df2_unit.sv
// Top level of the transposed direct form II IIR filter.
// Sequence: input transfer, b0*x, then b_k*x and a_k*y for each tap on the single
// shared MAC, then the result is loaded into the output register (held while it is full).
// A new sample is taken only when the previous result is loaded, so one sample at a time.
// Reset: synchronous, active low; clears the delay line, b0 to 1.0, other taps to 0.
module iir_filter_transposed_df2_unit #(
    parameter int ORDER = iirtdf2_pkg::ORDER_DEFAULT
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_wr_en,
    input  logic [iirtdf2_pkg::COEF_IDX_W-1:0]      i_cfg_index,
    input  logic [iirtdf2_pkg::COEF_W-1:0]          i_cfg_data,
    input  logic                                    i_in_valid,
    output logic                                    o_in_ready,
    input  logic signed [iirtdf2_pkg::SAMPLE_W-1:0] i_sample_in,
    input  logic                                    i_last_in,
    output logic                                    o_out_valid,
    input  logic                                    i_out_ready,
    output logic signed [iirtdf2_pkg::SAMPLE_W-1:0] o_sample_out,
    output logic                                    o_clipped,
    output logic                                    o_last_out
);

    iirtdf2_pkg::t_dp_cmd    cmd;
    iirtdf2_pkg::t_dp_status status;

    iirtdf2_ctrl #(
        .ORDER (ORDER)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    iirtdf2_dp #(
        .ORDER (ORDER)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_sample_in  (i_sample_in),
        .i_last_in    (i_last_in),
        .i_cmd        (cmd),
        .o_status     (status),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_sample_out (o_sample_out),
        .o_clipped    (o_clipped),
        .o_last_out   (o_last_out)
    );

endmodule

### rtl/core/iirtdf2_dp.sv
// Datapath: coefficient registers, shared MAC, delay line and output register.
module iirtdf2_dp #(
    parameter int ORDER = iirtdf2_pkg::ORDER_DEFAULT
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_cfg_wr_en,
    input  logic [iirtdf2_pkg::COEF_IDX_W-1:0]         i_cfg_index,
    input  logic [iirtdf2_pkg::COEF_W-1:0]             i_cfg_data,
    input  logic signed [iirtdf2_pkg::SAMPLE_W-1:0]    i_sample_in,
    input  logic                                       i_last_in,
    input  iirtdf2_pkg::t_dp_cmd                       i_cmd,
    output iirtdf2_pkg::t_dp_status                    o_status,
    output logic                                       o_out_valid,
    input  logic                                       i_out_ready,
    output logic signed [iirtdf2_pkg::SAMPLE_W-1:0]    o_sample_out,
    output logic                                       o_clipped,
    output logic                                       o_last_out
);

    localparam int SW  = iirtdf2_pkg::SAMPLE_W;
    localparam int CW  = iirtdf2_pkg::COEF_W;
    localparam int PW  = iirtdf2_pkg::PROD_W;
    localparam int DW  = iirtdf2_pkg::DLY_W;
    localparam int AW  = iirtdf2_pkg::ACC_W;
    localparam int UW  = iirtdf2_pkg::UPD_W;
    localparam int RSH = iirtdf2_pkg::ROUND_SH;
    localparam int YW  = AW - RSH;
    localparam int TW  = iirtdf2_pkg::TAP_W;

    localparam logic signed [AW-1:0] ROUND_HALF = AW'(1) <<< (RSH - 1);
    localparam logic signed [YW-1:0] Y_MAX      = YW'((1 << (SW - 1)) - 1);
    localparam logic signed [YW-1:0] Y_MIN      = -YW'(1 << (SW - 1));

    logic signed [CW-1:0] r_coef [iirtdf2_pkg::NUM_REGS];
    logic signed [DW-1:0] r_dly  [ORDER];
    logic signed [SW-1:0] r_x;
    logic                 r_last;
    logic signed [PW-1:0] r_prod;
    logic signed [AW-1:0] r_acc;
    logic signed [SW-1:0] r_y;
    logic                 r_clip;
    logic                 r_out_valid;
    logic signed [SW-1:0] r_out_sample;
    logic                 r_out_clip;
    logic                 r_out_last;

    logic signed [SW-1:0] mul_opd;
    logic signed [CW-1:0] mul_coef;
    logic signed [PW-1:0] mul_res;
    logic signed [AW-1:0] y_sum;
    logic signed [YW-1:0] y_shift;
    logic signed [SW-1:0] y_sat;
    logic                 clip_y;
    logic signed [DW-1:0] z_sel;
    logic signed [AW-1:0] acc_next;
    logic signed [UW-1:0] upd_sum;
    logic signed [DW-1:0] dly_next;
    logic                 clip_d;
    logic                 out_free;

    // shared 16x24 multiplier, operands sign-extended to the product width
    assign mul_opd  = i_cmd.mul_y ? r_y : r_x;
    assign mul_coef = r_coef[i_cmd.coef_idx];
    assign mul_res  = {{CW{mul_opd[SW-1]}}, mul_opd} * {{SW{mul_coef[CW-1]}}, mul_coef};

    // output sample: round half up then saturate
    assign y_sum   = {r_dly[0][DW-1], r_dly[0]} + {{(AW-PW){r_prod[PW-1]}}, r_prod}
                     + ROUND_HALF;
    assign y_shift = y_sum[AW-1:RSH];

    always_comb begin
        clip_y = 1'b0;
        y_sat  = y_shift[SW-1:0];
        if (y_shift > Y_MAX) begin
            y_sat  = Y_MAX[SW-1:0];
            clip_y = 1'b1;
        end else if (y_shift < Y_MIN) begin
            y_sat  = Y_MIN[SW-1:0];
            clip_y = 1'b1;
        end
    end

    // z[k], zero past the end of the line
    always_comb begin
        z_sel = '0;
        for (int i = 0; i < ORDER; i++) begin
            if (i_cmd.tap == TW'(i)) begin
                z_sel = r_dly[i];
            end
        end
    end

    assign acc_next = {z_sel[DW-1], z_sel} + {{(AW-PW){r_prod[PW-1]}}, r_prod};
    assign upd_sum  = {r_acc[AW-1], r_acc} - {{(UW-PW){r_prod[PW-1]}}, r_prod};

    always_comb begin
        clip_d   = 1'b0;
        dly_next = upd_sum[DW-1:0];
        if (upd_sum[UW-1:DW-1] != '0 && upd_sum[UW-1:DW-1] != '1) begin
            clip_d   = 1'b1;
            dly_next = upd_sum[UW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
        end
    end

    assign out_free          = !r_out_valid || i_out_ready;
    assign o_status.out_free = out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < iirtdf2_pkg::NUM_REGS; i++) begin
                r_coef[i] <= (i == int'(iirtdf2_pkg::REG_B0)) ?
                             iirtdf2_pkg::COEF_B0_RESET : '0;
            end
            for (int i = 0; i < ORDER; i++) begin
                r_dly[i] <= '0;
            end
            r_clip      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en && i_cfg_index < iirtdf2_pkg::COEF_IDX_W'(iirtdf2_pkg::NUM_REGS)) begin
                r_coef[i_cfg_index] <= i_cfg_data;
            end
            for (int i = 0; i < ORDER; i++) begin
                if (i_cmd.upd_en && i_cmd.tap == TW'(i + 1)) begin
                    r_dly[i] <= dly_next;
                end
            end
            if (i_cmd.load_x) begin
                r_clip <= 1'b0;
            end else if ((i_cmd.y_en && clip_y) || (i_cmd.upd_en && clip_d)) begin
                r_clip <= 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_x) begin
            r_x    <= i_sample_in;
            r_last <= i_last_in;
        end
        if (i_cmd.mul_en) begin
            r_prod <= mul_res;
        end
        if (i_cmd.y_en) begin
            r_y <= y_sat;
        end
        if (i_cmd.acc_en) begin
            r_acc <= acc_next;
        end
        if (i_cmd.out_load) begin
            r_out_sample <= r_y;
            r_out_clip   <= r_clip || (i_cmd.upd_en && clip_d);
            r_out_last   <= r_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_out_sample;
    assign o_clipped    = r_out_clip;
    assign o_last_out   = r_out_last;

endmodule

### rtl/core/iirtdf2_ctrl.sv
// Controller: sequences the shared MAC over the taps of one sample.
module iirtdf2_ctrl #(
    parameter int ORDER = iirtdf2_pkg::ORDER_DEFAULT
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  iirtdf2_pkg::t_dp_status i_status,
    output iirtdf2_pkg::t_dp_cmd    o_cmd
);

    localparam int TW = iirtdf2_pkg::TAP_W;
    localparam int CI = iirtdf2_pkg::COEF_IDX_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL0,
        S_YCALC,
        S_ACC,
        S_UPD,
        S_HOLD
    } t_state;

    t_state               r_state, n_state;
    logic [TW-1:0]        r_tap, n_tap;
    iirtdf2_pkg::t_dp_cmd cmd;
    logic                 ready;

    always_comb begin
        n_state = r_state;
        n_tap   = r_tap;
        cmd     = '0;
        ready   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                ready = 1'b1;
                if (i_in_valid) begin
                    cmd.load_x = 1'b1;
                    n_state    = S_MUL0;
                end
            end
            S_MUL0: begin
                cmd.mul_en   = 1'b1;
                cmd.coef_idx = iirtdf2_pkg::REG_B0;
                n_state      = S_YCALC;
            end
            S_YCALC: begin
                cmd.y_en     = 1'b1;
                cmd.mul_en   = 1'b1;
                cmd.coef_idx = CI'(TW'(1));
                n_tap        = TW'(1);
                n_state      = S_ACC;
            end
            S_ACC: begin
                cmd.acc_en   = 1'b1;
                cmd.tap      = r_tap;
                cmd.mul_en   = 1'b1;
                cmd.mul_y    = 1'b1;
                cmd.coef_idx = iirtdf2_pkg::REG_A_BASE + CI'(r_tap);
                n_state      = S_UPD;
            end
            S_UPD: begin
                cmd.upd_en = 1'b1;
                cmd.tap    = r_tap;
                if (r_tap != TW'(ORDER)) begin
                    cmd.mul_en   = 1'b1;
                    cmd.coef_idx = CI'(r_tap) + CI'(TW'(1));
                    n_tap        = r_tap + TW'(1);
                    n_state      = S_ACC;
                end else if (i_status.out_free) begin
                    cmd.out_load = 1'b1;
                    ready        = 1'b1;
                    if (i_in_valid) begin
                        cmd.load_x = 1'b1;
                        n_state    = S_MUL0;
                    end else begin
                        n_state = S_IDLE;
                    end
                end else begin
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (i_status.out_free) begin
                    cmd.out_load = 1'b1;
                    ready        = 1'b1;
                    if (i_in_valid) begin
                        cmd.load_x = 1'b1;
                        n_state    = S_MUL0;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_tap   <= '0;
        end else begin
            r_state <= n_state;
            r_tap   <= n_tap;
        end
    end

    assign o_cmd      = cmd;
    assign o_in_ready = ready;

    a_transfer_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_x |=> (r_state == S_MUL0))
        else $error("input transfer did not start the multiply sequence");

    a_tap_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACC || r_state == S_UPD) |-> (r_tap != '0 && r_tap <= TW'(ORDER)))
        else $error("tap index out of range");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> i_status.out_free)
        else $error("output register overwritten");

    a_ready_ctx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ready |-> (r_state == S_IDLE || cmd.out_load))
        else $error("ready raised mid-sample");

endmodule

### sim/iir_filter_checker.sv
// Checker for the IIR filter: predicts each filtered sample and compares the output stream.
module iir_filter_checker #(
    parameter int ORDER = iirtdf2_pkg::ORDER_DEFAULT
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_wr_en,
    input  logic [iirtdf2_pkg::COEF_IDX_W-1:0]      i_cfg_index,
    input  logic [iirtdf2_pkg::COEF_W-1:0]          i_cfg_data,
    input  logic                                    i_in_valid,
    input  logic                                    i_in_ready,
    input  logic signed [iirtdf2_pkg::SAMPLE_W-1:0] i_sample_in,
    input  logic                                    i_last_in,
    input  logic                                    i_out_valid,
    input  logic                                    i_out_ready,
    input  logic signed [iirtdf2_pkg::SAMPLE_W-1:0] i_sample_out,
    input  logic                                    i_clipped,
    input  logic                                    i_last_out,
    output int                                      o_fail_count,
    output int                                      o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint DLY_HI = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint DLY_LO = -DLY_HI - 1;
    localparam longint Y_HI   = 32767;
    localparam longint Y_LO   = -32768;

    typedef struct packed {
        logic signed [iirtdf2_pkg::SAMPLE_W-1:0] sample;
        logic                                    clipped;
        logic                                    last;
    } t_filt_result;

    logic signed [iirtdf2_pkg::COEF_W-1:0] coef [iirtdf2_pkg::NUM_REGS];
    longint                                dly  [ORDER];
    t_filt_result                          expected_q [$];
    t_filt_result                          exp_r;
    t_filt_result                          got_r;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // One filter step; advances the predicted delay line.
    function automatic t_filt_result filter_sample(
        input logic signed [iirtdf2_pkg::SAMPLE_W-1:0] x,
        input logic last_flag);
        longint       acc;
        longint       y;
        longint       v;
        t_filt_result r;
        r.clipped = 1'b0;
        r.last    = last_flag;
        acc = longint'(coef[iirtdf2_pkg::REG_B0]) * longint'(x) + dly[0];
        y   = (acc + longint'(1 << (iirtdf2_pkg::ROUND_SH - 1))) >>> iirtdf2_pkg::ROUND_SH;
        if (y > Y_HI) begin
            y = Y_HI;
            r.clipped = 1'b1;
        end else if (y < Y_LO) begin
            y = Y_LO;
            r.clipped = 1'b1;
        end
        for (int j = 0; j < ORDER; j++) begin
            v = (j + 1 < ORDER) ? dly[j+1] : 0;
            v = v + longint'(coef[j+1]) * longint'(x);
            v = v - longint'(coef[int'(iirtdf2_pkg::REG_A_BASE) + j + 1]) * y;
            if (v > DLY_HI) begin
                v = DLY_HI;
                r.clipped = 1'b1;
            end else if (v < DLY_LO) begin
                v = DLY_LO;
                r.clipped = 1'b1;
            end
            dly[j] = v;
        end
        r.sample = y[iirtdf2_pkg::SAMPLE_W-1:0];
        return r;
    endfunction

    task automatic log_fault(input string msg);
        if (o_fail_count < 10) begin
            $display("%0t: %s", $realtime, msg);
        end
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (coef[r]) coef[r] = '0;
            coef[iirtdf2_pkg::REG_B0] = iirtdf2_pkg::COEF_B0_RESET;
            foreach (dly[j]) dly[j] = 0;
            expected_q.delete();
        end else begin
            if (i_cfg_wr_en && i_cfg_index < iirtdf2_pkg::NUM_REGS) begin
                coef[i_cfg_index] = i_cfg_data;
            end
            if (i_out_valid && i_out_ready) begin
                got_r = '{sample: i_sample_out, clipped: i_clipped, last: i_last_out};
                if (expected_q.size() == 0) begin
                    log_fault($sformatf("unexpected transfer: sample %0d clipped %b last %b",
                                        i_sample_out, i_clipped, i_last_out));
                end else begin
                    exp_r = expected_q.pop_front();
                    if (got_r.sample !== exp_r.sample || got_r.clipped !== exp_r.clipped ||
                        got_r.last !== exp_r.last) begin
                        log_fault($sformatf(
                            "sample exp %0d got %0d, clipped exp %b got %b, last exp %b got %b",
                            exp_r.sample, got_r.sample, exp_r.clipped, got_r.clipped,
                            exp_r.last, got_r.last));
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                expected_q.push_back(filter_sample(i_sample_in, i_last_in));
            end
        end
        o_pending = expected_q.size();
    end

endmodule

### sim/tb_top.sv
// Testbench top for the IIR filter: clock, reset, stimulus and verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SAMPLE_W   = iirtdf2_pkg::SAMPLE_W;
    localparam int COEF_W     = iirtdf2_pkg::COEF_W;
    localparam int COEF_IDX_W = iirtdf2_pkg::COEF_IDX_W;
    localparam int NUM_REGS   = iirtdf2_pkg::NUM_REGS;

    localparam int ORDER   = iirtdf2_pkg::ORDER_DEFAULT;
    localparam int LATENCY = 2 + 2 * ORDER;
    localparam int LIMIT   = 400000;
    localparam int SEG_ITEMS = 78;

    localparam logic [COEF_W-1:0]   COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic [COEF_W-1:0]   COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};
    localparam logic [SAMPLE_W-1:0] SMP_MAX  = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic [SAMPLE_W-1:0] SMP_MIN  = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam logic [COEF_IDX_W-1:0] IDX_NONE = COEF_IDX_W'(NUM_REGS);

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_wr_en;
    logic [COEF_IDX_W-1:0]      cfg_index;
    logic [COEF_W-1:0]          cfg_data;
    logic                       in_valid;
    logic                       in_ready;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                       last_in;
    logic                       out_valid;
    logic                       out_ready;
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       clipped;
    logic                       last_out;
    int                         fail_count;
    int                         pending;
    int                         cycles;
    int                         send_idle_pct;
    int                         recv_idle_pct;

    iir_filter_transposed_df2_unit #(.ORDER(ORDER)) uut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_sample_in  (sample_in),
        .i_last_in    (last_in),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_sample_out (sample_out),
        .o_clipped    (clipped),
        .o_last_out   (last_out)
    );

    iir_filter_checker #(.ORDER(ORDER)) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_sample_in  (sample_in),
        .i_last_in    (last_in),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_sample_out (sample_out),
        .i_clipped    (clipped),
        .i_last_out   (last_out),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        in_valid      = 1'b0;
        sample_in     = '0;
        last_in       = 1'b0;
        out_ready     = 1'b0;
        cycles        = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
    end

    always #5 clk = ~clk;

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("iir_filter_transposed_df2_unit: mismatch");
            $finish;
        end
    end

    always @(negedge clk) begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    task automatic write_coef(input logic [COEF_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_sample(input logic [SAMPLE_W-1:0] x, input logic last_flag);
        int gap;
        gap = ($urandom_range(0, 99) < send_idle_pct) ? $urandom_range(1, 12) : 0;
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        sample_in <= x;
        last_in   <= last_flag;
        do @(posedge clk); while (!in_ready);
    endtask

    // Drop valid and wait until every result is back and the block takes input again.
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0 || !in_ready);
    endtask

    function automatic logic [COEF_W-1:0] rand_coef();
        case ($urandom_range(0, 5))
            0: return COEF_W'($urandom);
            1, 2: return COEF_W'($urandom_range(0, 1 << 21) - (1 << 20));
            3: return COEF_W'($urandom_range(0, 1 << 19) - (1 << 18));
            4: return $urandom_range(0, 1) ? COEF_MAX : COEF_MIN;
            default: return '0;
        endcase
    endfunction

    function automatic logic [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(0, 7))
            0: return $urandom_range(0, 1) ? SMP_MAX : SMP_MIN;
            1: return SAMPLE_W'($urandom_range(0, 128) - 64);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    initial begin
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // reset taps: pass-through
        send_sample(SMP_MAX, 1'b0);
        send_sample(SMP_MIN, 1'b0);
        send_sample('0, 1'b1);
        send_sample(SAMPLE_W'(1), 1'b0);
        send_sample({SAMPLE_W{1'b1}}, 1'b1);
        settle();

        // alternating extreme taps, plus a write to a missing register
        for (int r = 0; r < NUM_REGS; r++) begin
            write_coef(COEF_IDX_W'(r), (r % 2 == 0) ? COEF_MAX : COEF_MIN);
        end
        write_coef(IDX_NONE, COEF_MIN);
        send_sample(SMP_MAX, 1'b0);
        send_sample(SMP_MIN, 1'b1);
        send_sample(SMP_MAX, 1'b0);
        send_sample(SMP_MIN, 1'b0);
        send_sample('0, 1'b0);
        send_sample('0, 1'b1);
        settle();

        // all taps at the negative extreme
        for (int r = 0; r < NUM_REGS; r++) begin
            write_coef(COEF_IDX_W'(r), COEF_MIN);
        end
        send_sample({SAMPLE_W{1'b1}}, 1'b0);
        send_sample(SAMPLE_W'(1), 1'b0);
        send_sample(SMP_MIN, 1'b0);
        send_sample(SMP_MAX, 1'b1);
        send_sample('0, 1'b0);
        settle();

        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct = 33;
                    recv_idle_pct = 50;
                end
                1: begin
                    send_idle_pct = 50;
                    recv_idle_pct = 33;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int seg = 0; seg < 4; seg++) begin
                for (int r = 0; r < NUM_REGS; r++) begin
                    write_coef(COEF_IDX_W'(r), rand_coef());
                end
                if ($urandom_range(0, 3) == 0) begin
                    write_coef(IDX_NONE, COEF_W'($urandom));
                end
                for (int i = 0; i < SEG_ITEMS; i++) begin
                    send_sample(rand_sample(), $urandom_range(0, 7) == 0);
                end
                settle();
            end
        end

        repeat (LATENCY + 8) @(negedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("iir_filter_transposed_df2_unit: match");
        end else begin
            $display("iir_filter_transposed_df2_unit: mismatch");
        end
        $finish;
    end

endmodule
